[hw/rtl/rpfa_pkg.sv]
// shared types and constants of the page frame allocator
package rpfa_pkg;

    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned ROW_LANES  = 8;
    localparam int unsigned LANE_W     = 3;
    localparam int unsigned PAGES_W    = 13;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned DATA_W     = 32;

    localparam logic [PAGES_W-1:0] PAGES_RESET = 13'd4096;
    localparam logic               REG_PAGES_IN_USE = 1'b0;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_SHARE   = 2'd2;
    localparam logic [1:0] REQ_RESERVE = 2'd3;

    localparam logic [1:0] STAT_DONE         = 2'd0;
    localparam logic [1:0] STAT_OUT_OF_PAGES = 2'd1;
    localparam logic [1:0] STAT_REJECTED     = 2'd2;
    localparam logic [1:0] STAT_IGNORED      = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_MODIFY,
        ST_SCAN,
        ST_DELIVER
    } rpfa_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic lookup;
        logic reject;
        logic modify;
        logic scan;
        logic deliver;
    } rpfa_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_alloc;
        logic addr_ok;
        logic scan_hit;
        logic scan_miss;
        logic out_free;
    } rpfa_stat_t;

endpackage

[hw/rtl/refcounted_page_frame_allocator.sv]
// top level of the reference counted page frame allocator
// release, share, reserve: the item passes CHECK (row read), MODIFY (row written back)
// and DELIVER (output register, once free); a rejected address skips MODIFY, and the next
// item is taken in the cycle after delivery; allocate: one row of 8 counts read per cycle
// the count store's single read port sets the scan rate; one item is worked at a time
// after reset a clearing pass zeroes every row of the count store
// during that pass no item is taken; pages_in_use resets to 4096
module refcounted_page_frame_allocator
    import rpfa_pkg::*;
#(
    parameter int unsigned NUM_PAGES     = 4096,
    parameter int unsigned PAGE_SHIFT    = 12,
    parameter int unsigned RESERVED_MARK = 100,
    parameter logic [31:0] BASE_ADDRESS  = 32'h0010_0000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [DATA_W-1:0]     s_page_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_granted_address,
    output logic [1:0]            m_status
);

    logic [PAGES_W-1:0] pages_reg;
    logic               reg_sel;
    rpfa_cmd_t          cmd;
    rpfa_stat_t         stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[CFG_ADDR_W-1] == REG_PAGES_IN_USE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pages_reg <= PAGES_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            pages_reg <= pwdata[PAGES_W-1:0];
        end
    end

    assign prdata = reg_sel ? DATA_W'(pages_reg) : '0;

    rpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rpfa_datapath #(
        .NUM_PAGES     (NUM_PAGES),
        .PAGE_SHIFT    (PAGE_SHIFT),
        .RESERVED_MARK (RESERVED_MARK),
        .BASE_ADDRESS  (BASE_ADDRESS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .pages_in_use      (pages_reg),
        .s_req_type        (s_req_type),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status)
    );

endmodule

[hw/rtl/rpfa_ctrl.sv]
// request sequencer of the page frame allocator
module rpfa_ctrl
    import rpfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rpfa_stat_t stat,
    output rpfa_cmd_t  cmd
);

    rpfa_state_t state_reg;
    rpfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = stat.in_alloc ? ST_SCAN : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.addr_ok) begin
                    cmd.lookup = 1'b1;
                    state_next = ST_MODIFY;
                end else begin
                    cmd.reject = 1'b1;
                    state_next = ST_DELIVER;
                end
            end
            ST_MODIFY: begin
                cmd.modify = 1'b1;
                state_next = ST_DELIVER;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_hit || stat.scan_miss) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (stat.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear, cmd.start, cmd.lookup, cmd.reject, cmd.modify,
                  cmd.scan, cmd.deliver}))
        else $error("more than one command at once");

    a_ready_not_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready)
        else $error("item taken during clearing pass");

endmodule

[hw/rtl/rpfa_datapath.sv]
// count store, address decode, free page scan and result registers
module rpfa_datapath
    import rpfa_pkg::*;
#(
    parameter int unsigned NUM_PAGES     = 4096,
    parameter int unsigned PAGE_SHIFT    = 12,
    parameter int unsigned RESERVED_MARK = 100,
    parameter logic [31:0] BASE_ADDRESS  = 32'h0010_0000
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rpfa_cmd_t          cmd,
    output rpfa_stat_t         stat,
    input  logic [PAGES_W-1:0] pages_in_use,
    input  logic [1:0]         s_req_type,
    input  logic [DATA_W-1:0]  s_page_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DATA_W-1:0]  m_granted_address,
    output logic [1:0]         m_status
);

    localparam int unsigned ROWS     = (NUM_PAGES + ROW_LANES - 1) / ROW_LANES;
    localparam int unsigned ROW_W    = $clog2(ROWS);
    localparam int unsigned PG_W     = ROW_W + LANE_W;
    localparam int unsigned ROW_BITS = ROW_LANES * COUNT_W;
    localparam logic [COUNT_W-1:0] MARK = COUNT_W'(RESERVED_MARK);

    logic [ROW_BITS-1:0] mem [ROWS];

    logic [1:0]          req_reg;
    logic [DATA_W-1:0]   addr_reg;
    logic [ROW_W-1:0]    clear_row_reg;
    logic [ROW_W:0]      scan_row_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic                rd_valid_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic [DATA_W-1:0]   pend_granted_reg;
    logic [1:0]          pend_status_reg;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_granted_reg;
    logic [1:0]          m_status_reg;

    logic [31:0]         live;
    logic [31:0]         rel;
    logic [PG_W-1:0]     idx;
    logic [ROW_W-1:0]    idx_row;
    logic [LANE_W-1:0]   idx_lane;
    logic                addr_ok;
    logic [COUNT_W-1:0]  cur_count;
    logic [COUNT_W-1:0]  new_count;
    logic [1:0]          mod_status;
    logic [ROW_BITS-1:0] mod_row;
    logic [ROW_LANES-1:0] lane_free;
    logic                scan_issue;
    logic                scan_hit;
    logic                scan_miss;
    logic [LANE_W-1:0]   hit_lane;
    logic [ROW_BITS-1:0] hit_row;
    logic [DATA_W-1:0]   hit_address;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_raddr;
    logic                out_free;

    // address decode
    always_comb begin
        live     = (32'(pages_in_use) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : 32'(pages_in_use);
        rel      = (addr_reg - BASE_ADDRESS) >> PAGE_SHIFT;
        idx      = rel[PG_W-1:0];
        idx_row  = idx[PG_W-1:LANE_W];
        idx_lane = idx[LANE_W-1:0];
        addr_ok  = (addr_reg >= BASE_ADDRESS) && (addr_reg[PAGE_SHIFT-1:0] == '0)
                   && (rel < live);
    end

    // count update for release, share and reserve
    always_comb begin
        cur_count  = rd_data_reg[idx_lane*COUNT_W +: COUNT_W];
        new_count  = cur_count;
        mod_status = STAT_DONE;
        case (req_reg)
            REQ_RELEASE: begin
                if (cur_count == '0 || cur_count >= MARK) begin
                    mod_status = STAT_IGNORED;
                end else begin
                    new_count = cur_count - 1'b1;
                end
            end
            REQ_SHARE: begin
                if (cur_count >= MARK) begin
                    mod_status = STAT_IGNORED;
                end else if (cur_count < MARK - 1'b1) begin
                    new_count = cur_count + 1'b1;
                end
            end
            REQ_RESERVE: begin
                new_count = MARK;
            end
            default: begin
                new_count = cur_count;
            end
        endcase
        mod_row = rd_data_reg;
        mod_row[idx_lane*COUNT_W +: COUNT_W] = new_count;
    end

    // free page scan, one row of counts per cycle
    always_comb begin
        for (int l = 0; l < ROW_LANES; l++) begin
            lane_free[l] = (rd_data_reg[l*COUNT_W +: COUNT_W] == '0)
                           && (32'({rd_row_reg, LANE_W'(l)}) < live);
        end
        hit_lane = '0;
        for (int l = ROW_LANES - 1; l >= 0; l--) begin
            if (lane_free[l]) begin
                hit_lane = LANE_W'(l);
            end
        end
        scan_issue  = 32'({scan_row_reg, LANE_W'(0)}) < live;
        scan_hit    = rd_valid_reg && (|lane_free);
        scan_miss   = !rd_valid_reg && !scan_issue;
        hit_row     = rd_data_reg;
        hit_row[hit_lane*COUNT_W +: COUNT_W] = COUNT_W'(1);
        hit_address = BASE_ADDRESS + (32'({rd_row_reg, hit_lane}) << PAGE_SHIFT);
    end

    // memory port selection
    always_comb begin
        mem_we    = cmd.clear || cmd.modify || (cmd.scan && scan_hit);
        mem_waddr = rd_row_reg;
        mem_wdata = hit_row;
        if (cmd.clear) begin
            mem_waddr = clear_row_reg;
            mem_wdata = '0;
        end else if (cmd.modify) begin
            mem_waddr = idx_row;
            mem_wdata = mod_row;
        end
        mem_re    = cmd.lookup || (cmd.scan && scan_issue);
        mem_raddr = cmd.lookup ? idx_row : scan_row_reg[ROW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_row_reg <= '0;
            scan_row_reg  <= '0;
            rd_row_reg    <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clear_row_reg <= clear_row_reg + 1'b1;
            end
            if (cmd.start) begin
                scan_row_reg <= '0;
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_valid_reg <= scan_issue;
                if (scan_issue) begin
                    scan_row_reg <= scan_row_reg + 1'b1;
                    rd_row_reg   <= scan_row_reg[ROW_W-1:0];
                end
            end
        end
    end

    // item and pending result registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_reg  <= s_req_type;
            addr_reg <= s_page_address;
        end
        if (cmd.reject) begin
            pend_granted_reg <= '0;
            pend_status_reg  <= STAT_REJECTED;
        end else if (cmd.modify) begin
            pend_granted_reg <= '0;
            pend_status_reg  <= mod_status;
        end else if (cmd.scan && scan_hit) begin
            pend_granted_reg <= hit_address;
            pend_status_reg  <= STAT_DONE;
        end else if (cmd.scan && scan_miss) begin
            pend_granted_reg <= '0;
            pend_status_reg  <= STAT_OUT_OF_PAGES;
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.deliver) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            m_granted_reg <= pend_granted_reg;
            m_status_reg  <= pend_status_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_granted_reg;
    assign m_status          = m_status_reg;

    always_comb begin
        stat            = '0;
        stat.clear_last = clear_row_reg == ROW_W'(ROWS - 1);
        stat.in_alloc   = s_req_type == REQ_ALLOC;
        stat.addr_ok    = addr_ok;
        stat.scan_hit   = scan_hit;
        stat.scan_miss  = scan_miss;
        stat.out_free   = out_free;
    end

    a_deliver_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deliver |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != STAT_DONE) |-> m_granted_reg == '0)
        else $error("address given with a failing status");

    a_hit_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && scan_hit) |-> $past(cmd.scan))
        else $error("scan hit without a row read");

endmodule

[tb/refcounted_page_frame_allocator_tb.sv]
// testbench of the reference counted page frame allocator with a self-checking count store
`timescale 1ns / 100ps

module refcounted_page_frame_allocator_tb;
    import rpfa_pkg::*;

    localparam int unsigned NUM_PAGES     = 4096;
    localparam int unsigned PAGE_SHIFT    = 12;
    localparam int unsigned RESERVED_MARK = 100;
    localparam logic [31:0] BASE_ADDRESS  = 32'h0010_0000;
    localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
    localparam int unsigned PIDX_W        = $clog2(NUM_PAGES);

    localparam logic [CFG_ADDR_W-1:0] PAGES_ADDR = CFG_ADDR_W'(4 * REG_PAGES_IN_USE);
    localparam int unsigned UNMAPPED_INDEX = 1;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = CFG_ADDR_W'(4 * UNMAPPED_INDEX);

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [DATA_W-1:0] granted;
        logic [1:0]        status;
    } grant_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [DATA_W-1:0]     s_page_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [DATA_W-1:0]     m_granted_address;
    logic [1:0]            m_status;

    logic [COUNT_W-1:0] page_counts [NUM_PAGES];
    logic [PAGES_W-1:0] page_limit;
    grant_result_t      pending_results [$];
    grant_result_t      oldest;
    int unsigned        fail_count;
    int unsigned        cycle_count;
    int unsigned        sink_stall_pct;
    logic               hold_request;

    refcounted_page_frame_allocator #(
        .NUM_PAGES     (NUM_PAGES),
        .PAGE_SHIFT    (PAGE_SHIFT),
        .RESERVED_MARK (RESERVED_MARK),
        .BASE_ADDRESS  (BASE_ADDRESS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned effective_pages();
        return (page_limit > NUM_PAGES) ? NUM_PAGES : int'(page_limit);
    endfunction

    function automatic logic [31:0] page_addr(input int unsigned idx);
        return BASE_ADDRESS + (idx << PAGE_SHIFT);
    endfunction

    function automatic void predict_grant(input logic [1:0] req, input logic [31:0] addr,
                                          output grant_result_t res);
        int unsigned live;
        logic [31:0] rel;
        logic [PIDX_W-1:0] pidx;
        logic [COUNT_W-1:0] cnt;
        res.granted = '0;
        res.status  = STAT_DONE;
        live = effective_pages();
        if (req == REQ_ALLOC) begin
            res.status = STAT_OUT_OF_PAGES;
            for (int i = 0; i < live; i++) begin
                if (page_counts[PIDX_W'(i)] == '0) begin
                    page_counts[PIDX_W'(i)] = COUNT_W'(1);
                    res.granted = page_addr(i);
                    res.status  = STAT_DONE;
                    break;
                end
            end
        end else begin
            rel = (addr - BASE_ADDRESS) >> PAGE_SHIFT;
            pidx = rel[PIDX_W-1:0];
            if (addr < BASE_ADDRESS || addr[PAGE_SHIFT-1:0] != '0 || rel >= live) begin
                res.status = STAT_REJECTED;
            end else begin
                cnt = page_counts[pidx];
                case (req)
                    REQ_RELEASE: begin
                        if (cnt == '0 || cnt >= RESERVED_MARK) res.status = STAT_IGNORED;
                        else page_counts[pidx] = cnt - 1'b1;
                    end
                    REQ_SHARE: begin
                        if (cnt >= RESERVED_MARK) res.status = STAT_IGNORED;
                        else if (cnt < RESERVED_MARK - 1) page_counts[pidx] = cnt + 1'b1;
                    end
                    default: begin
                        page_counts[pidx] = COUNT_W'(RESERVED_MARK);
                    end
                endcase
            end
        end
    endfunction

    // result sink: own stall pattern, plus a long hold-off on request
    initial begin : result_sink
        int unsigned run_left;
        int unsigned hold_left;
        logic ready_now;
        run_left  = 0;
        hold_left = 0;
        ready_now = 1'b1;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_now = ($urandom_range(99) >= sink_stall_pct);
                    run_left = $urandom_range(8, 1);
                end
                run_left--;
                m_ready <= ready_now;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected item: granted_address %h status %0d",
                       m_granted_address, m_status);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_granted_address !== oldest.granted) begin
                    $error("granted_address: expected %h, actual %h",
                           oldest.granted, m_granted_address);
                    fail_count++;
                end
                if (m_status !== oldest.status) begin
                    $error("status: expected %0d, actual %0d", oldest.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [31:0] addr);
        grant_result_t want;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_page_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_grant(req, addr, want);
        pending_results.push_back(want);
    endtask

    task automatic idle_input(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        idle_input(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == PAGES_ADDR) page_limit = data[PAGES_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] random_page_address(input int unsigned live);
        int unsigned span;
        span = (live > 32) ? 32 : live;
        case ($urandom_range(9))
            0: return $urandom();
            1: return page_addr($urandom_range(live)) | $urandom_range(PAGE_BYTES - 1, 1);
            2: return $urandom_range(BASE_ADDRESS - 1);
            3: return page_addr(live + $urandom_range(1));
            4: return (live == 0) ? page_addr(0) : page_addr($urandom_range(live - 1));
            default: return (span == 0) ? page_addr(0) : page_addr($urandom_range(span - 1));
        endcase
    endfunction

    task automatic send_random_item(input int unsigned alloc_pct);
        int unsigned roll;
        logic [1:0] req;
        roll = $urandom_range(99);
        if (roll < alloc_pct) req = REQ_ALLOC;
        else if (roll < alloc_pct + (100 - alloc_pct) * 45 / 100) req = REQ_RELEASE;
        else if (roll < 95) req = REQ_SHARE;
        else req = REQ_RESERVE;
        send_request(req, random_page_address(effective_pages()));
    endtask

    task automatic test_directed();
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_SHARE, page_addr(0));
        send_request(REQ_RELEASE, page_addr(0));
        send_request(REQ_RELEASE, page_addr(0));
        send_request(REQ_RELEASE, page_addr(0));
        send_request(REQ_RELEASE, BASE_ADDRESS - PAGE_BYTES);
        send_request(REQ_SHARE, 32'h0000_0000);
        send_request(REQ_RESERVE, 32'hFFFF_FFFF);
        send_request(REQ_RELEASE, BASE_ADDRESS + 1);
        send_request(REQ_SHARE, BASE_ADDRESS + PAGE_BYTES / 2);
        send_request(REQ_RESERVE, page_addr(NUM_PAGES));
        send_request(REQ_SHARE, page_addr(NUM_PAGES - 1));
        send_request(REQ_RESERVE, page_addr(NUM_PAGES - 1));
        send_request(REQ_RELEASE, page_addr(NUM_PAGES - 1));
        send_request(REQ_SHARE, page_addr(NUM_PAGES - 1));
        send_request(REQ_RESERVE, page_addr(NUM_PAGES - 1));
        send_request(REQ_RESERVE, page_addr(0));
        send_request(REQ_ALLOC, 32'h5555_5555);
        send_request(REQ_RELEASE, page_addr(1));
        send_request(REQ_ALLOC, 32'hAAAA_AAAA);
        wait_for_results();
    endtask

    task automatic test_page_limits();
        write_reg(PAGES_ADDR, 32'd0);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, page_addr(0));
        send_request(REQ_SHARE, page_addr(0));
        send_request(REQ_RESERVE, page_addr(0));
        wait_for_results();
        write_reg(UNMAPPED_ADDR, 32'd2);
        send_request(REQ_ALLOC, 32'h0);
        wait_for_results();
        write_reg(PAGES_ADDR, 32'd2);
        repeat (3) send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_RELEASE, page_addr(1));
        send_request(REQ_SHARE, page_addr(2));
        wait_for_results();
        write_reg(PAGES_ADDR, 32'd8191);
        send_request(REQ_SHARE, page_addr(NUM_PAGES - 1));
        send_request(REQ_RELEASE, page_addr(NUM_PAGES));
        wait_for_results();
        write_reg(PAGES_ADDR, 32'hFFFF_E001);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_SHARE, page_addr(1));
        wait_for_results();
    endtask

    task automatic test_share_ceiling();
        write_reg(PAGES_ADDR, 32'd16);
        repeat (RESERVED_MARK + 1) send_request(REQ_SHARE, page_addr(3));
        send_request(REQ_RELEASE, page_addr(3));
        send_request(REQ_SHARE, page_addr(3));
        send_request(REQ_SHARE, page_addr(3));
        send_request(REQ_RESERVE, page_addr(3));
        send_request(REQ_SHARE, page_addr(3));
        wait_for_results();
    endtask

    task automatic test_result_backpressure();
        write_reg(PAGES_ADDR, 32'd16);
        sink_stall_pct = 0;
        hold_request = 1'b1;
        repeat (12) send_random_item(30);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int unsigned settings [10];
        int unsigned items;
        int unsigned burst_left;
        int unsigned alloc_pct;
        logic [31:0] cfg_word;
        settings = '{16, 5, 1, 64, 0, 8191, 37, 4096, 24, 12};
        burst_left = 0;
        foreach (settings[p]) begin
            cfg_word = settings[p];
            if ($urandom_range(1) == 1) cfg_word = cfg_word | ($urandom() & 32'hFFFF_E000);
            write_reg(PAGES_ADDR, cfg_word);
            if (effective_pages() >= NUM_PAGES) items = 25;
            else if (effective_pages() == 0) items = 10;
            else items = 45;
            alloc_pct = $urandom_range(45, 15);
            sink_stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(70, 10);
            for (int n = 0; n < items; n++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(2) != 0) idle_input($urandom_range(6, 1));
                    burst_left = $urandom_range(12, 1);
                end
                send_random_item(alloc_pct);
                burst_left--;
            end
            wait_for_results();
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_req_type     <= REQ_ALLOC;
        s_page_address <= '0;
        fail_count     = 0;
        cycle_count    = 0;
        sink_stall_pct = 30;
        hold_request   = 1'b0;
        foreach (page_counts[i]) page_counts[i] = '0;
        page_limit = PAGES_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_page_limits();
        test_share_ceiling();
        test_result_backpressure();
        test_random_traffic();

        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
